/* sv/lifo_stack_search_replace_unit_macros.svh */
// Assertion macros for the LIFO stack search/replace unit.
// Used by lssr_checker.sv; depends on nothing else.
`ifndef LIFO_STACK_SEARCH_REPLACE_UNIT_MACROS_SVH
`define LIFO_STACK_SEARCH_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lssr_pkg.sv */
// Shared types and constants of the LIFO stack search/replace unit.
// No dependencies.
package lssr_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 7;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  new_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    status_e                   status;
    logic        [COUNT_W-1:0] entry_count;
    logic                      stack_empty;
  } rsp_t;

endpackage

/* sv/lssr_chan.sv */
// Valid/ready channel carrying one request or response payload.
// Payload type is set per instance; uses no package.
interface lssr_chan #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/lssr_store.sv */
// Entry store: single write port, single registered read port.
// Depends on lssr_pkg for the word width.
module lssr_store import lssr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lssr_ctrl.sv */
// Sequencer of the stack: count, push/pop, and the top-down scan with one comparator.
// Depends on lssr_pkg; drives the ports of lssr_store.
module lssr_ctrl import lssr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  req_t                     req_i,
  output logic                     req_ready_o,
  input  logic                     slot_free_i,
  output logic                     res_valid_o,
  output rsp_t                     res_o,
  output logic                     we_o,
  output logic [AW-1:0]            waddr_o,
  output logic signed [DATA_W-1:0] wdata_o,
  output logic [AW-1:0]            raddr_o,
  input  logic signed [DATA_W-1:0] rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] nv_q, nv_d;
  logic                     upd_q, upd_d;
  logic signed [DATA_W-1:0] rd_q, rd_d;
  status_e                  st_q, st_d;

  logic [CW-1:0]            cnt_m1;
  logic                     hit;
  logic                     req_fire;
  logic [CW+COUNT_W-1:0]    cnt_ext;

  assign cnt_m1   = cnt_q - CW'(1);
  assign hit      = (rdata_i == key_q);
  assign req_fire = req_valid_i && req_ready_o;
  assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_q};

  assign req_ready_o = (state_q == S_IDLE);
  assign raddr_o     = (state_q == S_SCAN) ? (idx_q - AW'(1)) : cnt_m1[AW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    key_d   = key_q;
    nv_d    = nv_q;
    upd_d   = upd_q;
    rd_d    = rd_q;
    st_d    = st_q;
    we_o    = 1'b0;
    waddr_o = cnt_q[AW-1:0];
    wdata_o = req_i.value;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          key_d   = req_i.value;
          nv_d    = req_i.new_value;
          upd_d   = (req_i.operation == OP_UPDATE);
          rd_d    = '0;
          st_d    = ST_OK;
          state_d = S_RESP;
          case (req_i.operation)
            OP_PUSH: begin
              if (cnt_q == CW'(DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                we_o  = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                rd_d = '1;
                st_d = ST_EMPTY;
              end else begin
                cnt_d   = cnt_m1;
                state_d = S_POP;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                idx_d   = cnt_m1[AW-1:0];
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end
      S_POP: begin
        rd_d    = rdata_i;
        state_d = S_RESP;
      end
      S_SCAN: begin
        // rdata_i holds the entry at idx_q; the next lower one is being read
        if (hit) begin
          we_o    = upd_q;
          waddr_o = idx_q;
          wdata_o = nv_q;
          state_d = S_RESP;
        end else if (idx_q == '0) begin
          st_d    = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          idx_d = idx_q - AW'(1);
        end
      end
      S_RESP: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    nv_q  <= nv_d;
    upd_q <= upd_d;
    rd_q  <= rd_d;
    st_q  <= st_d;
  end

  assign res_valid_o       = (state_q == S_RESP);
  assign res_o.read_value  = rd_q;
  assign res_o.status      = st_q;
  assign res_o.entry_count = cnt_ext[COUNT_W-1:0];
  assign res_o.stack_empty = (cnt_q == '0);

endmodule

/* sv/lifo_stack_search_replace_unit.sv */
// Top level of the LIFO stack search/replace unit: sequencer, entry store, output register.
// Depends on lssr_pkg, lssr_chan, lssr_ctrl and lssr_store.
//
//   channel  dir  modport  payload  notes
//   req_i    in   sink     req_t    operation, value, new_value
//   rsp_o    out  source   rsp_t    read_value, status, entry_count, stack_empty
//
// Push, full push and any operation on an empty stack respond without reading the entry store.
// Pop: one registered read of the entry store before the response.
// Search/update: the scan reads one entry per cycle through the store's single read port,
// top first, and stops at the first match. One request at a time; a new request is taken
// while a response waits in the output register. Reset clears the entry count, the
// sequencer state and the output valid flag; store contents are not cleared.
module lifo_stack_search_replace_unit import lssr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lssr_chan.sink   req_i,
  lssr_chan.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [AW-1:0]            raddr;
  logic signed [DATA_W-1:0] rdata;

  logic res_valid;
  rsp_t res;

  // output register: one response may wait here while the next request runs
  logic out_valid_q;
  rsp_t out_q;
  logic slot_free;

  assign slot_free = !out_valid_q || rsp_o.ready;

  lssr_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (req_i.payload),
    .req_ready_o (req_i.ready),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  lssr_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  // sequencer leaves its response state on slot_free, so each response loads once
  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

/* sv/lssr_checker.sv */
// Port-level checker for the LIFO stack search/replace unit, with its bind.
// Depends on lssr_pkg and lifo_stack_search_replace_unit_macros.svh.
`include "lifo_stack_search_replace_unit_macros.svh"

module lssr_checker import lssr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_i
);

  localparam logic [COUNT_W-1:0] FullCount = COUNT_W'(DEPTH);

  `LSSR_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "response dropped while stalled")
  `LSSR_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")
  `LSSR_ASSERT_NOW(a_empty_count, clk_i, rst_ni, rsp_valid_i && rsp_i.stack_empty, rsp_i.entry_count == '0, "empty flag with nonzero count")
  `LSSR_ASSERT_NOW(a_full_count, clk_i, rst_ni, rsp_valid_i && rsp_i.status == ST_FULL, rsp_i.entry_count == FullCount && rsp_i.read_value == '0, "full status with wrong count")

endmodule

bind lifo_stack_search_replace_unit lssr_checker #(
  .DEPTH (DEPTH)
) u_lssr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);
